// File: rtl/typed_value_match_filter_assert.svh
// Assertion macros for the typed value match filter.
`ifndef TYPED_VALUE_MATCH_FILTER_ASSERT_SVH
`define TYPED_VALUE_MATCH_FILTER_ASSERT_SVH
// Implication checked on every clock edge outside reset.
`define TVMF_ASSERT_IMP(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("assertion failed");
// Next-cycle implication.
`define TVMF_ASSERT_NXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("assertion failed");
`endif

// File: rtl/tvmf_pkg.sv
// ----------------------------------------------------------------------------
// tvmf_pkg
// Types, codes and helpers for the typed value match filter.
// ----------------------------------------------------------------------------
package tvmf_pkg;

  typedef enum logic [3:0] {
    DT_I8 = 4'd0, DT_I16 = 4'd1, DT_I32 = 4'd2, DT_I64 = 4'd3,
    DT_F32 = 4'd4, DT_F64 = 4'd5, DT_ANY_INT = 4'd6, DT_ANY_FLT = 4'd7,
    DT_ANY_NUM = 4'd8
  } data_type_t;

  typedef enum logic [2:0] {
    MT_ANY = 3'd0, MT_EQ = 3'd1, MT_NE = 3'd2, MT_CHANGED = 3'd3,
    MT_UNCHANGED = 3'd4, MT_INC = 3'd5, MT_DEC = 3'd6
  } match_type_t;

  localparam logic [1:0] CFG_DATA_TYPE = 2'd0;
  localparam logic [1:0] CFG_MATCH_TYPE = 2'd1;
  localparam logic [1:0] CFG_REVERSE = 2'd2;

  typedef struct packed {
    logic [63:0] new_word;
    logic [9:0]  new_views;
    logic        allow_forward;
    logic        allow_reverse;
    logic [63:0] ref_word;
    logic [9:0]  ref_views;
  } in_item_t;

  typedef struct packed {
    logic       matched;
    logic [9:0] matched_views;
    logic       forward_hit;
    logic       reverse_hit;
  } out_item_t;

  typedef struct packed {
    logic [3:0] data_type;
    logic [2:0] match_type;
    logic       reverse_detect;
  } cfg_t;

  // Per-view relation flags.
  typedef struct packed {
    logic [9:0] lt;
    logic [9:0] gt;
    logic [9:0] eq;
  } rel_t;

  function automatic logic [9:0] type_select(input logic [3:0] dt);
    logic [9:0] s;
    unique case (dt)
      DT_I8:      s = 10'h003;
      DT_I16:     s = 10'h00C;
      DT_I32:     s = 10'h030;
      DT_I64:     s = 10'h0C0;
      DT_F32:     s = 10'h100;
      DT_F64:     s = 10'h200;
      DT_ANY_INT: s = 10'h0FF;
      DT_ANY_FLT: s = 10'h300;
      DT_ANY_NUM: s = 10'h3FF;
      default:    s = 10'h000;
    endcase
    return s;
  endfunction

endpackage

// File: rtl/tvmf_compare.sv
// ----------------------------------------------------------------------------
// tvmf_compare
// Integer, float-order and float-truncation relations for all ten views.
// ----------------------------------------------------------------------------
module tvmf_compare (
  input  logic [63:0]    a,
  input  logic [63:0]    b,
  output tvmf_pkg::rel_t ord,  // ordered relations (floats IEEE)
  output tvmf_pkg::rel_t trc   // float views truncated to integers
);

  // Sign-magnitude float ordering; unordered gives none of lt/gt/eq.
  function automatic logic [2:0] fcmp64(input logic [63:0] x, input logic [63:0] y,
                                        input logic nan_any);
    logic xz, yz, lt, gt, eq;
    xz = (x[62:0] == 63'd0);
    yz = (y[62:0] == 63'd0);
    eq = 1'b0; lt = 1'b0; gt = 1'b0;
    if (!nan_any) begin
      if (xz && yz) eq = 1'b1;
      else if (x == y) eq = 1'b1;
      else if (x[63] != y[63]) begin
        lt = x[63]; gt = y[63];
      end else if (!x[63]) begin
        lt = x[62:0] < y[62:0]; gt = x[62:0] > y[62:0];
      end else begin
        lt = x[62:0] > y[62:0]; gt = x[62:0] < y[62:0];
      end
    end
    return {lt, gt, eq};
  endfunction

  // Truncate double toward zero to signed 64, saturating; NaN -> 0.
  function automatic logic [63:0] trunc_d(input logic [63:0] d);
    logic [10:0]  e;
    logic [52:0]  m;
    logic [116:0] sh;
    logic [63:0]  mag;
    logic [63:0]  r;
    e = d[62:52];
    m = {1'b1, d[51:0]};
    sh = '0;
    mag = '0;
    if (e == 11'h7FF && d[51:0] != 52'd0) r = 64'd0;
    else if (e >= 11'd1086) r = d[63] ? 64'h8000_0000_0000_0000 : 64'h7FFF_FFFF_FFFF_FFFF;
    else if (e < 11'd1023) r = 64'd0;
    else begin
      sh = {64'd0, m} << (e - 11'd1023);
      mag = sh[115:52];
      r = d[63] ? (~mag + 64'd1) : mag;
    end
    return r;
  endfunction

  function automatic logic [31:0] trunc_f(input logic [31:0] f);
    logic [7:0]  e;
    logic [23:0] m;
    logic [54:0] sh;
    logic [31:0] mag;
    logic [31:0] r;
    e = f[30:23];
    m = {1'b1, f[22:0]};
    sh = '0;
    mag = '0;
    if (e == 8'hFF && f[22:0] != 23'd0) r = 32'd0;
    else if (e >= 8'd158) r = f[31] ? 32'h8000_0000 : 32'h7FFF_FFFF;
    else if (e < 8'd127) r = 32'd0;
    else begin
      sh = {31'd0, m} << (e - 8'd127);
      mag = sh[54:23];
      r = f[31] ? (~mag + 32'd1) : mag;
    end
    return r;
  endfunction

  logic [2:0]  f32_rel, f64_rel;
  logic        nan32, nan64;
  logic [31:0] ta32, tb32;
  logic [63:0] ta64, tb64;
  logic [63:0] xa, xb;

  always_comb begin
    nan32 = (a[30:23] == 8'hFF && a[22:0] != 23'd0) || (b[30:23] == 8'hFF && b[22:0] != 23'd0);
    nan64 = (a[62:52] == 11'h7FF && a[51:0] != 52'd0)
         || (b[62:52] == 11'h7FF && b[51:0] != 52'd0);
    f32_rel = fcmp64({a[31], 32'd0, a[30:0]}, {b[31], 32'd0, b[30:0]}, nan32);
    f64_rel = fcmp64(a, b, nan64);
    ta32 = trunc_f(a[31:0]);
    tb32 = trunc_f(b[31:0]);
    ta64 = trunc_d(a);
    tb64 = trunc_d(b);
    ord = '0;
    trc = '0;
    for (int w = 0; w < 4; w++) begin
      for (int s = 0; s < 2; s++) begin
        xa = a;
        xb = b;
        for (int k = 0; k < 64; k++) begin
          if (k >= (8 << w)) begin
            xa[k] = 1'b0; xb[k] = 1'b0;
          end
        end
        if (s == 0) begin
          xa[(8 << w) - 1] = ~xa[(8 << w) - 1];
          xb[(8 << w) - 1] = ~xb[(8 << w) - 1];
        end
        ord.lt[2*w+s] = xa < xb;
        ord.gt[2*w+s] = xa > xb;
        ord.eq[2*w+s] = xa == xb;
      end
    end
    trc = ord;
    {ord.lt[8], ord.gt[8], ord.eq[8]} = f32_rel;
    {ord.lt[9], ord.gt[9], ord.eq[9]} = f64_rel;
    trc.eq[8] = ta32 == tb32;
    trc.lt[8] = $signed(ta32) < $signed(tb32);
    trc.gt[8] = $signed(ta32) > $signed(tb32);
    trc.eq[9] = ta64 == tb64;
    trc.lt[9] = $signed(ta64) < $signed(tb64);
    trc.gt[9] = $signed(ta64) > $signed(tb64);
  end

endmodule

// File: rtl/tvmf_decide.sv
// ----------------------------------------------------------------------------
// tvmf_decide
// Applies the configured test to the view relations and forms the result.
// ----------------------------------------------------------------------------
module tvmf_decide (
  input  tvmf_pkg::cfg_t     cfg,
  input  tvmf_pkg::in_item_t item,
  input  tvmf_pkg::rel_t     ord,
  input  tvmf_pkg::rel_t     trc,
  output tvmf_pkg::out_item_t res
);

  logic [9:0] base, both, eqv, fwd, rev, views;
  logic       rmode;

  always_comb begin
    base = tvmf_pkg::type_select(cfg.data_type) & item.new_views;
    both = base & item.ref_views;
    eqv = {trc.eq[9:8], ord.eq[7:0]};
    fwd = '0;
    rev = '0;
    views = '0;
    rmode = cfg.reverse_detect
         && (cfg.match_type == tvmf_pkg::MT_INC || cfg.match_type == tvmf_pkg::MT_DEC);
    case (cfg.match_type) inside
      tvmf_pkg::MT_ANY:       views = base;
      tvmf_pkg::MT_EQ:        views = both & eqv;
      tvmf_pkg::MT_NE,
      tvmf_pkg::MT_CHANGED:   views = both & ~ord.eq;
      tvmf_pkg::MT_UNCHANGED: views = both & ord.eq;
      tvmf_pkg::MT_INC: begin
        fwd = both & ord.gt;
        rev = both & ord.lt;
      end
      tvmf_pkg::MT_DEC: begin
        fwd = both & ord.lt;
        rev = both & ord.gt;
      end
      default: views = '0;
    endcase
    res = '0;
    if (rmode) begin
      fwd = item.allow_forward ? fwd : 10'd0;
      rev = item.allow_reverse ? rev : 10'd0;
      views = fwd | rev;
      res.forward_hit = |fwd;
      res.reverse_hit = |rev;
    end else if (cfg.match_type == tvmf_pkg::MT_INC || cfg.match_type == tvmf_pkg::MT_DEC) begin
      views = fwd;
    end
    res.matched_views = views;
    res.matched = |views;
  end

endmodule

// File: rtl/typed_value_match_filter.sv
// Result path: an input transfer loads the input register, and the result register takes
// the item from it when the result register is empty or being drained.
// Throughput: one item per cycle; the result register holds while out_ready is low,
// and the input register refills as soon as the result register can take its item.
// Reset (rst_n low, synchronous): both stages emptied, data_type, match_type and
// reverse_detect cleared to 0.
// ----------------------------------------------------------------------------
// typed_value_match_filter
// Two-stage registered filter: input register, combinational compare, result register.
// ----------------------------------------------------------------------------
`include "typed_value_match_filter_assert.svh"
module typed_value_match_filter (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_valid,
  output logic                 in_ready,
  input  tvmf_pkg::in_item_t   in_data,
  output logic                 out_valid,
  input  logic                 out_ready,
  output tvmf_pkg::out_item_t  out_data,
  input  logic                 cfg_valid,
  output logic                 cfg_ready,
  input  logic [1:0]           cfg_index,
  input  logic [3:0]           cfg_data
);

  tvmf_pkg::cfg_t      cfg_r;
  tvmf_pkg::in_item_t  item_r;
  logic                item_vld_r;
  tvmf_pkg::out_item_t res_r;
  logic                res_vld_r;
  tvmf_pkg::rel_t      ord, trc;
  tvmf_pkg::out_item_t res_nxt;
  logic                adv;

  // Configuration is always taken; the user must write it only while idle (not enforced here).
  assign cfg_ready = 1'b1;

  // Stage 1 moves on when the result register is empty or being drained.
  assign adv      = !res_vld_r || out_ready;
  assign in_ready = !item_vld_r || adv;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r <= '0;
    end else if (cfg_valid) begin
      unique case (cfg_index)
        tvmf_pkg::CFG_DATA_TYPE:  cfg_r.data_type      <= cfg_data;
        tvmf_pkg::CFG_MATCH_TYPE: cfg_r.match_type     <= cfg_data[2:0];
        tvmf_pkg::CFG_REVERSE:    cfg_r.reverse_detect <= cfg_data[0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      item_vld_r <= 1'b0;
      res_vld_r  <= 1'b0;
    end else begin
      if (in_ready) item_vld_r <= in_valid;
      if (adv) res_vld_r <= item_vld_r;
    end
  end

  // Payload registers, no reset.
  always_ff @(posedge clk) begin
    if (in_ready && in_valid) item_r <= in_data;
    if (adv && item_vld_r) res_r <= res_nxt;
  end

  tvmf_compare u_cmp (
    .a   (item_r.new_word),
    .b   (item_r.ref_word),
    .ord (ord),
    .trc (trc)
  );

  tvmf_decide u_dec (
    .cfg  (cfg_r),
    .item (item_r),
    .ord  (ord),
    .trc  (trc),
    .res  (res_nxt)
  );

  assign out_valid = res_vld_r;
  assign out_data  = res_r;

  `TVMF_ASSERT_IMP(a_match_or, out_valid, out_data.matched == (|out_data.matched_views))
  `TVMF_ASSERT_NXT(a_hold, out_valid && !out_ready, out_valid && $stable(out_data))
  `TVMF_ASSERT_IMP(a_hits_rev, !cfg_r.reverse_detect, !(res_nxt.forward_hit || res_nxt.reverse_hit))

endmodule

// File: tb/typed_value_match_filter_tb.sv
// ----------------------------------------------------------------------------
// Typed value match filter testbench
// Drives candidate/reference word pairs through the filter under a sweep of
// data type, match type and reverse settings, and checks every result
// against an independent bit-level predictor of the ten type views.
// ----------------------------------------------------------------------------
module typed_value_match_filter_tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned StallLimit = 5000;
  localparam int unsigned LongHold = 300;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic in_ready;
  tvmf_pkg::in_item_t in_data = '0;
  logic out_valid;
  logic out_ready = 1'b0;
  tvmf_pkg::out_item_t out_data;
  logic cfg_valid = 1'b0;
  logic cfg_ready;
  logic [1:0] cfg_index = '0;
  logic [3:0] cfg_data = '0;

  // Predictor's copy of the registers, updated on each cfg transfer.
  logic [3:0] sel_type = 4'd0;
  logic [2:0] test_kind = 3'd0;
  logic rev_mode = 1'b0;

  tvmf_pkg::out_item_t pending_results[$];
  int unsigned fail_count = 0;
  int unsigned quiet_cycles = 0;
  bit no_idle = 1'b0;
  bit hold_rx = 1'b0;

  typed_value_match_filter u_dut (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_ready(in_ready), .in_data(in_data),
    .out_valid(out_valid), .out_ready(out_ready), .out_data(out_data),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
    .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // ---------------------------------------------------------------------------
  // Predictor: everything worked out on raw bits, no reals involved.
  // ---------------------------------------------------------------------------

  // Float truncated toward zero to a w-bit signed integer; NaN gives 0,
  // out of range saturates by sign (infinities included).
  function automatic longint float_to_int(input logic [63:0] b, input bit dbl);
    int exp_w, man_w, bias, w, ex;
    logic sgn;
    longint e_raw, man, mag;
    begin
      exp_w = dbl ? 11 : 8;
      man_w = dbl ? 52 : 23;
      bias = dbl ? 1023 : 127;
      w = dbl ? 64 : 32;
      sgn = dbl ? b[63] : b[31];
      e_raw = dbl ? longint'(b[62:52]) : longint'(b[30:23]);
      man = dbl ? longint'(b[51:0]) : longint'(b[22:0]);
      if (e_raw == (64'd1 << exp_w) - 1 && man != 0) return 0;
      ex = int'(e_raw) - bias;
      if (ex < 0) return 0;
      if (ex >= w - 1) begin
        if (dbl) return sgn ? 64'h8000_0000_0000_0000 : 64'h7FFF_FFFF_FFFF_FFFF;
        return sgn ? -64'sd2147483648 : 64'sd2147483647;
      end
      mag = (64'sd1 <<< man_w) | man;
      if (ex >= man_w) mag = mag <<< (ex - man_w);
      else mag = mag >>> (man_w - ex);
      return sgn ? -mag : mag;
    end
  endfunction

  // IEEE ordering: -1 less, 0 equal, 1 greater, 2 unordered.
  function automatic int float_order(input logic [63:0] a, input logic [63:0] b,
                                     input bit dbl);
    logic sa, sb;
    logic [62:0] ma, mb, inf_mag;
    begin
      sa = dbl ? a[63] : a[31];
      sb = dbl ? b[63] : b[31];
      ma = dbl ? a[62:0] : 63'(a[30:0]);
      mb = dbl ? b[62:0] : 63'(b[30:0]);
      inf_mag = dbl ? 63'h7FF0_0000_0000_0000 : 63'h7F80_0000;
      if (ma > inf_mag || mb > inf_mag) return 2;
      if (ma == 0 && mb == 0) return 0;
      if (sa != sb) return sa ? -1 : 1;
      if (ma == mb) return 0;
      if (sa) return (ma > mb) ? -1 : 1;
      return (ma > mb) ? 1 : -1;
    end
  endfunction

  function automatic int view_order(input int v, input logic [63:0] a,
                                    input logic [63:0] b, input bit trunc);
    logic [63:0] msk, sgn, x, y;
    longint ta, tb;
    int bits;
    begin
      if (v < 8) begin
        bits = 8 << (v >> 1);
        msk = (bits == 64) ? '1 : ((64'd1 << bits) - 1);
        sgn = 64'd1 << (bits - 1);
        x = a & msk;
        y = b & msk;
        if (v % 2 == 0) begin
          x ^= sgn;
          y ^= sgn;
        end
        return (x < y) ? -1 : ((x > y) ? 1 : 0);
      end
      if (trunc) begin
        ta = float_to_int(a, v == 9);
        tb = float_to_int(b, v == 9);
        return (ta < tb) ? -1 : ((ta > tb) ? 1 : 0);
      end
      return float_order(a, b, v == 9);
    end
  endfunction

  function automatic logic [9:0] views_for(input logic [3:0] dt);
    case (dt)
      tvmf_pkg::DT_I8:      return 10'h003;
      tvmf_pkg::DT_I16:     return 10'h00C;
      tvmf_pkg::DT_I32:     return 10'h030;
      tvmf_pkg::DT_I64:     return 10'h0C0;
      tvmf_pkg::DT_F32:     return 10'h100;
      tvmf_pkg::DT_F64:     return 10'h200;
      tvmf_pkg::DT_ANY_INT: return 10'h0FF;
      tvmf_pkg::DT_ANY_FLT: return 10'h300;
      tvmf_pkg::DT_ANY_NUM: return 10'h3FF;
      default:              return 10'h000;
    endcase
  endfunction

  function automatic logic [9:0] passing_views(input logic [2:0] mt,
                                               input tvmf_pkg::in_item_t x);
    logic [9:0] hits, sel;
    int r;
    bit ok;
    begin
      hits = '0;
      sel = views_for(sel_type);
      for (int v = 0; v < 10; v++) begin
        if (!(sel[v] && x.new_views[v])) continue;
        if (mt == tvmf_pkg::MT_ANY) begin
          hits[v] = 1'b1;
          continue;
        end
        if (!x.ref_views[v]) continue;
        r = view_order(v, x.new_word, x.ref_word, mt == tvmf_pkg::MT_EQ && v >= 8);
        case (mt) inside
          tvmf_pkg::MT_EQ, tvmf_pkg::MT_UNCHANGED: ok = (r == 0);
          tvmf_pkg::MT_NE, tvmf_pkg::MT_CHANGED:   ok = (r != 0);
          tvmf_pkg::MT_INC:                        ok = (r == 1);
          tvmf_pkg::MT_DEC:                        ok = (r == -1);
          default:                                 ok = 1'b0;
        endcase
        hits[v] = ok;
      end
      return hits;
    end
  endfunction

  function automatic tvmf_pkg::out_item_t predict_match(input tvmf_pkg::in_item_t x);
    tvmf_pkg::out_item_t res;
    logic [9:0] fwd, rev;
    begin
      res = '0;
      if (rev_mode && (test_kind == tvmf_pkg::MT_INC || test_kind == tvmf_pkg::MT_DEC)) begin
        fwd = x.allow_forward ? passing_views(test_kind, x) : '0;
        rev = x.allow_reverse ?
              passing_views(test_kind == tvmf_pkg::MT_INC ? tvmf_pkg::MT_DEC
                                                          : tvmf_pkg::MT_INC, x) : '0;
        res.matched_views = fwd | rev;
        res.forward_hit = |fwd;
        res.reverse_hit = |rev;
      end else begin
        res.matched_views = passing_views(test_kind, x);
      end
      res.matched = |res.matched_views;
      return res;
    end
  endfunction

  // ---------------------------------------------------------------------------
  // Monitors: predict on input transfer, check on result transfer.
  // ---------------------------------------------------------------------------
  always @(posedge clk) begin
    if (rst_n) begin
      if (in_valid && in_ready) pending_results.push_back(predict_match(in_data));
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          tvmf_pkg::CFG_DATA_TYPE:  sel_type <= cfg_data;
          tvmf_pkg::CFG_MATCH_TYPE: test_kind <= cfg_data[2:0];
          tvmf_pkg::CFG_REVERSE:    rev_mode <= cfg_data[0];
          default: ;
        endcase
      end
    end
  end

  always @(posedge clk) begin
    tvmf_pkg::out_item_t want;
    if (rst_n && out_valid && out_ready) begin
      if (pending_results.size() == 0) begin
        $error("result transfer with nothing expected");
        fail_count++;
      end else begin
        want = pending_results.pop_front();
        if (out_data.matched !== want.matched) begin
          $error("matched: expected %0h, got %0h", want.matched, out_data.matched);
          fail_count++;
        end
        if (out_data.matched_views !== want.matched_views) begin
          $error("matched_views: expected %0h, got %0h",
                 want.matched_views, out_data.matched_views);
          fail_count++;
        end
        if (out_data.forward_hit !== want.forward_hit) begin
          $error("forward_hit: expected %0h, got %0h",
                 want.forward_hit, out_data.forward_hit);
          fail_count++;
        end
        if (out_data.reverse_hit !== want.reverse_hit) begin
          $error("reverse_hit: expected %0h, got %0h",
                 want.reverse_hit, out_data.reverse_hit);
          fail_count++;
        end
      end
    end
  end

  // Watchdog: any transfer on any channel counts as progress.
  always @(posedge clk) begin
    if ((in_valid && in_ready) || (out_valid && out_ready) || (cfg_valid && cfg_ready))
      quiet_cycles <= 0;
    else
      quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles >= StallLimit) begin
      $display("typed_value_match_filter test failed");
      $finish;
    end
  end

  // Receiver: random stall bursts, one long hold-off on request.
  initial begin
    @(posedge clk iff rst_n);
    forever begin
      if (hold_rx) begin
        out_ready <= 1'b0;
        repeat (LongHold) @(posedge clk);
        hold_rx = 1'b0;
      end else if (!no_idle && $urandom_range(7) == 0) begin
        out_ready <= 1'b0;
        repeat ($urandom_range(15, 1)) @(posedge clk);
      end else begin
        out_ready <= 1'b1;
        @(posedge clk);
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Stimulus helpers
  // ---------------------------------------------------------------------------
  task automatic send_item(input tvmf_pkg::in_item_t x);
    if (!no_idle && $urandom_range(7) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(15, 1)) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data <= x;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
  endtask

  task automatic stop_sending();
    in_valid <= 1'b0;
    @(posedge clk);
  endtask

  task automatic wait_drained();
    while (pending_results.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  // Register writes only with the pipe empty.
  task automatic write_reg(input logic [1:0] idx, input logic [3:0] val);
    stop_sending();
    wait_drained();
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    cfg_valid <= 1'b0;
    @(posedge clk);
  endtask

  task automatic set_mode(input logic [3:0] dt, input logic [2:0] mt, input logic rv);
    write_reg(tvmf_pkg::CFG_DATA_TYPE, dt);
    write_reg(tvmf_pkg::CFG_MATCH_TYPE, {1'b0, mt});
    write_reg(tvmf_pkg::CFG_REVERSE, {3'b0, rv});
  endtask

  function automatic logic [63:0] rand_word();
    case ($urandom_range(7))
      0: return {$urandom, $urandom};
      1: return 64'($urandom_range(4));
      2: return {$urandom, 1'b0, 8'hFF, 23'($urandom)};           // f32 inf/NaN
      3: return {1'b0, 11'h7FF, 52'({$urandom, $urandom})};          // f64 inf/NaN
      4: return {$urandom, 1'($urandom), 8'($urandom_range(160, 120)), 23'($urandom)};
      5: return {1'($urandom), 11'($urandom_range(1090, 1000)), 52'({$urandom, $urandom})};
      6: return {$urandom, $urandom} & 64'h8000_0000_8000_8080;
      default: return '1 ^ 64'($urandom_range(3));
    endcase
  endfunction

  function automatic tvmf_pkg::in_item_t rand_item();
    tvmf_pkg::in_item_t x;
    x.new_word = rand_word();
    case ($urandom_range(5))
      0, 1: x.ref_word = x.new_word;
      2: x.ref_word = x.new_word + 64'($urandom_range(2)) - 64'd1;
      3: x.ref_word = x.new_word ^ (64'd1 << $urandom_range(63));
      default: x.ref_word = rand_word();
    endcase
    x.new_views = ($urandom_range(3) != 0) ? 10'h3FF : 10'($urandom);
    x.ref_views = ($urandom_range(3) != 0) ? 10'h3FF : 10'($urandom);
    x.allow_forward = ($urandom_range(3) != 0);
    x.allow_reverse = ($urandom_range(3) != 0);
    return x;
  endfunction

  function automatic tvmf_pkg::in_item_t pair(input logic [63:0] nw, input logic [63:0] rw);
    tvmf_pkg::in_item_t x;
    x.new_word = nw;
    x.ref_word = rw;
    x.new_views = 10'h3FF;
    x.ref_views = 10'h3FF;
    x.allow_forward = 1'b1;
    x.allow_reverse = 1'b1;
    return x;
  endfunction

  // ---------------------------------------------------------------------------
  // Tests
  // ---------------------------------------------------------------------------

  // Reset state is match-any on i8; view masks gate the result.
  task automatic test_reset_defaults();
    tvmf_pkg::in_item_t x;
    x = pair('1, '0);
    send_item(x);
    x.new_views = 10'h001;
    x.ref_views = '0;
    send_item(x);
    x.new_views = '0;
    send_item(x);
  endtask

  // Float equality by truncation, NaN, signed zeros, saturation, sign edge.
  task automatic test_float_equal();
    set_mode(tvmf_pkg::DT_ANY_NUM, tvmf_pkg::MT_EQ, 1'b0);
    send_item(pair(64'h3FC0_0000, 64'h3FF3_3333));                   // 1.5 vs 1.9 (f32)
    send_item(pair(64'h7FC0_0000, 64'h0));                           // f32 NaN vs 0
    send_item(pair(64'h7FF8_0000_0000_0000, 64'h0));                 // f64 NaN vs 0
    send_item(pair(64'h8000_0000_8000_0000, 64'h0));                 // -0 vs +0 (f32)
    send_item(pair(64'h4F00_0000, 64'h7F80_0000));                   // 2^31 vs +inf
    send_item(pair(64'hCF00_0001, 64'hFF80_0000));                   // below -2^31 vs -inf
    send_item(pair(64'h43E0_0000_0000_0000, 64'h7FF0_0000_0000_0000));
    send_item(pair(64'hC3E0_0000_0000_0000, 64'hC3E0_0000_0000_0001));
    send_item(pair(64'h80, 64'h7F));
  endtask

  // Every match type once, including the undefined code, plus bad data type.
  task automatic test_match_kinds();
    for (int mt = tvmf_pkg::MT_ANY; mt <= 7; mt++) begin
      set_mode(tvmf_pkg::DT_ANY_NUM, 3'(mt), 1'b0);
      send_item(pair(64'hFFFF_FFFF_FFFF_FFFF, 64'h0));
    end
    set_mode(4'd15, tvmf_pkg::MT_NE, 1'b0);
    send_item(pair('1, '0));
  endtask

  // Reverse mode with each allow combination, both directions.
  task automatic test_reverse_gating();
    tvmf_pkg::in_item_t x;
    set_mode(tvmf_pkg::DT_ANY_INT, tvmf_pkg::MT_INC, 1'b1);
    for (int k = 0; k < 4; k++) begin
      x = pair(64'h0000_0000_0000_0081, 64'h0000_0000_0000_0001);
      x.allow_forward = k[0];
      x.allow_reverse = k[1];
      send_item(x);
    end
    set_mode(tvmf_pkg::DT_ANY_FLT, tvmf_pkg::MT_DEC, 1'b1);
    send_item(pair(64'hBF80_0000, 64'h3F80_0000));
  endtask

  // Random phases, each under a fresh configuration; the early ones walk
  // every data type code and every match type code.
  task automatic test_random_sweep();
    logic [3:0] dt;
    logic [2:0] mt;
    for (int ph = 0; ph < 20; ph++) begin
      dt = (ph < 16) ? 4'(ph) : 4'($urandom_range(8));
      mt = (ph < 8) ? 3'(ph) : 3'($urandom_range(6));
      set_mode(dt, mt, 1'($urandom_range(1)));
      repeat (60) send_item(rand_item());
    end
  endtask

  // Receiver holds off while the sender keeps offering: pipe fills, input stalls.
  task automatic test_backpressure();
    set_mode(tvmf_pkg::DT_ANY_NUM, tvmf_pkg::MT_CHANGED, 1'b0);
    hold_rx = 1'b1;
    repeat (40) send_item(rand_item());
    stop_sending();
    wait_drained();
    repeat (20) send_item(rand_item());
  endtask

  // Full-rate finish with no idling on either side.
  task automatic test_full_rate();
    set_mode(tvmf_pkg::DT_ANY_NUM, tvmf_pkg::MT_INC, 1'b1);
    no_idle = 1'b1;
    repeat (150) send_item(rand_item());
    stop_sending();
  endtask

  initial begin
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_reset_defaults();
    test_float_equal();
    test_match_kinds();
    test_reverse_gating();
    test_random_sweep();
    test_backpressure();
    test_full_rate();
    while (pending_results.size() != 0) @(posedge clk);
    repeat (10) @(posedge clk);
    if (fail_count == 0 && pending_results.size() == 0)
      $display("typed_value_match_filter test passed");
    else
      $display("typed_value_match_filter test failed");
    $finish;
  end

endmodule
